[sv/voc_pcm_block_deframer_core_defines.svh]
// Assertion macros used by the deframer core RTL.
`ifndef VOC_PCM_BLOCK_DEFRAMER_CORE_DEFINES_SVH
`define VOC_PCM_BLOCK_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define VOCPBD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define VOCPBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VOCPBD_ASSERT_SAME(label, ante, cons, msg)
`define VOCPBD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[sv/vocpbd_pkg.sv]
package vocpbd_pkg;

  localparam int WRAPPER_BYTES_DEF    = 16;
  localparam int VOC_HEADER_BYTES_DEF = 26;

  // wrapper magic and type
  localparam logic [7:0]  MAGIC0        = 8'hAF;
  localparam logic [7:0]  MAGIC1        = 8'hDE;
  localparam logic [15:0] WRAP_TYPE_SFX = 16'd2;
  localparam int POS_MAGIC0  = 0;
  localparam int POS_MAGIC1  = 1;
  localparam int POS_TYPE_LO = 2;
  localparam int POS_TYPE_HI = 3;

  // block header codes
  localparam logic [7:0] BLK_SOUND  = 8'd1;
  localparam logic [7:0] CODEC_PCM8 = 8'd0;

  localparam logic [7:0] SIGN_FLIP = 8'h80;

  localparam int CNT_W  = 17;
  localparam int SEEN_W = 18;
  localparam logic [CNT_W-1:0]  CAP_MIN  = 17'd2;
  localparam logic [CNT_W-1:0]  CAP_MAX  = 17'd131070;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 18'h3FFFF;

  // status codes
  localparam logic [1:0] ST_PLAY    = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_NOT_SFX = 2'd2;

  // result kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // period = PERIOD_NUM / (FREQ_NUM / (256 - tc))
  localparam int DVD_W = 22;
  localparam int DVS_W = 20;
  localparam logic [DVD_W-1:0] FREQ_NUM   = 22'd1000000;
  localparam logic [DVD_W-1:0] PERIOD_NUM = 22'd3546895;
  localparam logic [8:0]       TC_BASE    = 9'd256;

  typedef struct packed {
    logic              emit;
    logic [7:0]        sample;
    logic [CNT_W-1:0]  index;
    logic [1:0]        status;
    logic [CNT_W-1:0]  count;
    logic [7:0]        tc;
  } parse_res_t;

endpackage

[sv/vocpbd_if.sv]
interface vocpbd_entry_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vocpbd_result_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic signed [7:0] sample;
  logic [16:0]       sample_index;
  logic [1:0]        status;
  logic [16:0]       sample_count;
  logic [7:0]        time_constant;
  logic [9:0]        period;
  logic              last;

  modport source (output valid, output kind, output sample, output sample_index,
                  output status, output sample_count, output time_constant,
                  output period, output last, input ready);
  modport sink   (input valid, input kind, input sample, input sample_index,
                  input status, input sample_count, input time_constant,
                  input period, input last, output ready);
endinterface

[sv/vocpbd_div.sv]
module vocpbd_div #(
  parameter int N_W = vocpbd_pkg::DVD_W,
  parameter int D_W = vocpbd_pkg::DVS_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int STEP_W = $clog2(N_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [D_W-1:0]    rem;
  logic [D_W-1:0]    dvs;
  logic [N_W-1:0]    quo;
  logic [D_W:0]      trial;
  logic [D_W:0]      diff;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quo[N_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= STEP_W'(N_W);
      rem   <= '0;
      dvs   <= divisor;
      quo   <= dividend;
    end else if (busy) begin
      rem   <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
      quo   <= {quo[N_W-2:0], fits};
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient = quo;

endmodule

[sv/vocpbd_parse.sv]
module vocpbd_parse #(
  parameter int WRAPPER_BYTES    = vocpbd_pkg::WRAPPER_BYTES_DEF,
  parameter int VOC_HEADER_BYTES = vocpbd_pkg::VOC_HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  input  logic [vocpbd_pkg::CNT_W-1:0] max_samples,
  output vocpbd_pkg::parse_res_t       res
);

  localparam int HDR_TOTAL = WRAPPER_BYTES + VOC_HEADER_BYTES;
  localparam int HPOS_W    = $clog2(HDR_TOTAL + 1);

  typedef enum logic [1:0] {PH_HEADER, PH_BLKHDR, PH_DATA, PH_STOPPED} phase_t;

  phase_t                           phase, phase_next;
  logic [HPOS_W-1:0]                hpos, hpos_next;
  logic [2:0]                       bpos, bpos_next;
  logic [23:0]                      bbl, bbl_next;
  logic [7:0]                       ltc, ltc_next;
  logic [7:0]                       ptc, ptc_next;
  logic [7:0]                       type_low, type_low_next;
  logic [vocpbd_pkg::SEEN_W-1:0]    seen, seen_next;
  logic [1:0]                       rej, rej_next;
  logic [vocpbd_pkg::CNT_W-1:0]     cap;
  logic [vocpbd_pkg::CNT_W-1:0]     kept;

  always_comb begin
    if (max_samples < vocpbd_pkg::CAP_MIN) begin
      cap = vocpbd_pkg::CAP_MIN;
    end else if (max_samples > vocpbd_pkg::CAP_MAX) begin
      cap = vocpbd_pkg::CAP_MAX;
    end else begin
      cap = max_samples;
    end
  end

  always_comb begin
    phase_next    = phase;
    hpos_next     = hpos;
    bpos_next     = bpos;
    bbl_next      = bbl;
    ltc_next      = ltc;
    ptc_next      = ptc;
    type_low_next = type_low;
    seen_next     = seen;
    rej_next      = rej;
    res           = '0;
    kept          = '0;

    case (phase)
      PH_HEADER: begin
        if (hpos == HPOS_W'(vocpbd_pkg::POS_MAGIC0) && data_byte != vocpbd_pkg::MAGIC0) begin
          rej_next = vocpbd_pkg::ST_REJECT;
        end
        if (hpos == HPOS_W'(vocpbd_pkg::POS_MAGIC1) && data_byte != vocpbd_pkg::MAGIC1) begin
          rej_next = vocpbd_pkg::ST_REJECT;
        end
        if (hpos == HPOS_W'(vocpbd_pkg::POS_TYPE_LO)) begin
          type_low_next = data_byte;
        end
        hpos_next = hpos + 1'b1;
        if (hpos == HPOS_W'(vocpbd_pkg::POS_TYPE_HI)) begin
          if (rej == vocpbd_pkg::ST_PLAY &&
              {data_byte, type_low} != vocpbd_pkg::WRAP_TYPE_SFX) begin
            rej_next = vocpbd_pkg::ST_NOT_SFX;
          end
          if (rej_next != vocpbd_pkg::ST_PLAY) begin
            phase_next = PH_STOPPED;
          end
        end
        if (phase_next == PH_HEADER && hpos == HPOS_W'(HDR_TOTAL - 1)) begin
          phase_next = PH_BLKHDR;
        end
      end
      PH_BLKHDR: begin
        case (bpos)
          3'd0: begin
            if (data_byte != vocpbd_pkg::BLK_SOUND) begin
              phase_next = PH_STOPPED;
            end else begin
              bbl_next  = '0;
              bpos_next = 3'd1;
            end
          end
          3'd1: begin
            bbl_next[7:0] = data_byte;
            bpos_next     = 3'd2;
          end
          3'd2: begin
            bbl_next[15:8] = data_byte;
            bpos_next      = 3'd3;
          end
          3'd3: begin
            bbl_next[23:16] = data_byte;
            bpos_next       = 3'd4;
          end
          3'd4: begin
            ptc_next  = data_byte;
            bpos_next = 3'd5;
          end
          default: begin
            bpos_next = 3'd0;
            if (bbl < 24'd2 || data_byte != vocpbd_pkg::CODEC_PCM8) begin
              phase_next = PH_STOPPED;
            end else begin
              ltc_next   = ptc;
              bbl_next   = bbl - 24'd2;
              phase_next = (bbl_next != '0) ? PH_DATA : PH_BLKHDR;
            end
          end
        endcase
      end
      PH_DATA: begin
        if (seen < {1'b0, cap}) begin
          res.emit   = 1'b1;
          res.sample = data_byte ^ vocpbd_pkg::SIGN_FLIP;
          res.index  = seen[vocpbd_pkg::CNT_W-1:0];
        end
        if (seen < vocpbd_pkg::SEEN_MAX) begin
          seen_next = seen + 1'b1;
        end
        bbl_next = bbl - 24'd1;
        if (bbl_next == '0) begin
          phase_next = PH_BLKHDR;
        end
      end
      default: begin
        // stopped: drop bytes until the end of the entry
      end
    endcase

    // summary fields, valid when last_byte is set
    if (rej_next != vocpbd_pkg::ST_PLAY) begin
      res.status = rej_next;
    end else if (phase == PH_HEADER || seen_next < 18'd2) begin
      res.status = vocpbd_pkg::ST_REJECT;
    end else begin
      res.status = vocpbd_pkg::ST_PLAY;
      kept       = (seen_next < {1'b0, cap}) ? seen_next[vocpbd_pkg::CNT_W-1:0] : cap;
      res.count  = {kept[vocpbd_pkg::CNT_W-1:1], 1'b0};
      res.tc     = ltc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (en && last_byte)) begin
      phase    <= PH_HEADER;
      hpos     <= '0;
      bpos     <= '0;
      bbl      <= '0;
      ltc      <= '0;
      ptc      <= '0;
      type_low <= '0;
      seen     <= '0;
      rej      <= vocpbd_pkg::ST_PLAY;
    end else if (en) begin
      phase    <= phase_next;
      hpos     <= hpos_next;
      bpos     <= bpos_next;
      bbl      <= bbl_next;
      ltc      <= ltc_next;
      ptc      <= ptc_next;
      type_low <= type_low_next;
      seen     <= seen_next;
      rej      <= rej_next;
    end
  end

endmodule

[sv/voc_pcm_block_deframer_core.sv]
// A sample word appears on result in the cycle after its byte is taken.
// Throughput: one byte per cycle while the result register drains each cycle and no summary is pending.
// The last byte of an entry ends in a summary: when playable it waits for two divisions
// on one shared restoring divider, otherwise it waits only for a free result register.
// Reset (rst, synchronous): parser state cleared, max_samples back to 131070.
`include "voc_pcm_block_deframer_core_defines.svh"

module voc_pcm_block_deframer_core #(
  parameter int WRAPPER_BYTES    = vocpbd_pkg::WRAPPER_BYTES_DEF,
  parameter int VOC_HEADER_BYTES = vocpbd_pkg::VOC_HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [vocpbd_pkg::CNT_W-1:0] cfg_wr_data,
  vocpbd_entry_if.sink                 entry,
  vocpbd_result_if.source              result
);

  typedef enum logic [1:0] {S_IDLE, S_DIV_FREQ, S_DIV_PER, S_SUM} state_t;

  state_t                        state;
  logic [vocpbd_pkg::CNT_W-1:0]  max_samples;
  vocpbd_pkg::parse_res_t        pres;

  // summary held while the divider works
  logic [1:0]                    sum_status;
  logic [vocpbd_pkg::CNT_W-1:0]  sum_count;
  logic [7:0]                    sum_tc;
  logic [9:0]                    sum_period;

  logic                          slot_free;
  logic                          take;
  logic                          load_sample;
  logic                          load_sum;
  logic                          div_start;
  logic                          div_done;
  logic [vocpbd_pkg::DVD_W-1:0]  div_dividend;
  logic [vocpbd_pkg::DVS_W-1:0]  div_divisor;
  logic [vocpbd_pkg::DVD_W-1:0]  div_quotient;
  logic [8:0]                    tc_span;

  // terms for the checks below
  logic                          in_div;
  logic                          last_take;
  logic                          bad_sum;
  logic                          sum_zero;
  logic                          held_sample;

  // The result register frees up in the same cycle it is taken.
  assign slot_free   = !result.valid || result.ready;
  assign entry.ready = (state == S_IDLE) && slot_free;
  assign take        = entry.valid && entry.ready;

  // A word enters the result register from a sample byte or from a summary.
  assign load_sample = take && pres.emit;
  assign load_sum    = (state == S_SUM) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= vocpbd_pkg::CAP_MAX;
    end else if (cfg_wr_en) begin
      max_samples <= cfg_wr_data;
    end
  end

  vocpbd_parse #(
    .WRAPPER_BYTES    (WRAPPER_BYTES),
    .VOC_HEADER_BYTES (VOC_HEADER_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .en          (take),
    .data_byte   (entry.data_byte),
    .last_byte   (entry.last_byte),
    .max_samples (max_samples),
    .res         (pres)
  );

  // First pass: freq = 1000000 / (256 - tc). Second: period = 3546895 / freq.
  assign tc_span   = vocpbd_pkg::TC_BASE - {1'b0, pres.tc};
  assign div_start = (take && entry.last_byte && pres.status == vocpbd_pkg::ST_PLAY) ||
                     (state == S_DIV_FREQ && div_done);

  always_comb begin
    if (state == S_DIV_FREQ) begin
      div_dividend = vocpbd_pkg::PERIOD_NUM;
      div_divisor  = div_quotient[vocpbd_pkg::DVS_W-1:0];
    end else begin
      div_dividend = vocpbd_pkg::FREQ_NUM;
      div_divisor  = {{(vocpbd_pkg::DVS_W - 9){1'b0}}, tc_span};
    end
  end

  vocpbd_div #(
    .N_W (vocpbd_pkg::DVD_W),
    .D_W (vocpbd_pkg::DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      // load a new word, else drain the result register once it is taken
      if (load_sample || load_sum) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            if (pres.emit) begin
              result.kind          <= vocpbd_pkg::KIND_SAMPLE;
              result.sample        <= pres.sample;
              result.sample_index  <= pres.index;
              result.status        <= vocpbd_pkg::ST_PLAY;
              result.sample_count  <= '0;
              result.time_constant <= '0;
              result.period        <= '0;
              result.last          <= !entry.last_byte;
            end
            if (entry.last_byte) begin
              sum_status <= pres.status;
              sum_count  <= pres.count;
              sum_tc     <= pres.tc;
              sum_period <= '0;
              state      <= (pres.status == vocpbd_pkg::ST_PLAY) ? S_DIV_FREQ : S_SUM;
            end
          end
        end
        S_DIV_FREQ: begin
          if (div_done) begin
            state <= S_DIV_PER;
          end
        end
        S_DIV_PER: begin
          if (div_done) begin
            sum_period <= div_quotient[9:0];
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          // hold the summary until the result register is free
          if (slot_free) begin
            result.kind          <= vocpbd_pkg::KIND_SUMMARY;
            result.sample        <= '0;
            result.sample_index  <= '0;
            result.status        <= sum_status;
            result.sample_count  <= sum_count;
            result.time_constant <= sum_tc;
            result.period        <= sum_period;
            result.last          <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_div      = (state == S_DIV_FREQ) || (state == S_DIV_PER);
  assign last_take   = take && entry.last_byte;
  assign bad_sum     = result.valid && result.kind == vocpbd_pkg::KIND_SUMMARY &&
                       result.status != vocpbd_pkg::ST_PLAY;
  assign sum_zero    = result.sample_count == '0 && result.time_constant == '0 &&
                       result.period == '0;
  assign held_sample = result.valid && result.kind == vocpbd_pkg::KIND_SAMPLE &&
                       state != S_IDLE;

  // The divider finishes only while a summary is being worked out.
  `VOCPBD_ASSERT_SAME(a_div_done_in_div, div_done, in_div, "divider done outside a division")
  // After the last byte of an entry no byte is taken until its summary is out.
  `VOCPBD_ASSERT_NEXT(a_hold_after_last, last_take, !entry.ready, "byte taken before summary")
  // A summary that is not playable carries no count, time constant or period.
  `VOCPBD_ASSERT_SAME(a_bad_summary_zero, bad_sum, sum_zero, "rejected summary has fields set")
  // A sample word is never flagged as the final word while a summary follows.
  `VOCPBD_ASSERT_SAME(a_sample_not_last, held_sample, !result.last, "sample marked last early")

endmodule

[dv/voc_pcm_block_deframer_core_tb.sv]
module voc_pcm_block_deframer_core_tb;
  import vocpbd_pkg::*;

  // Wrapper plus VOC header: bytes swallowed before the first block header.
  localparam int unsigned HDR_TOTAL = WRAPPER_BYTES_DEF + VOC_HEADER_BYTES_DEF;
  // Filler after magic and type so that a head reaches the first block header.
  localparam int unsigned HDR_FILL = HDR_TOTAL - 4;
  // Guard after the last expected word: covers the two-division summary path.
  localparam int unsigned TAIL_CYCLES = 60;
  // Cycles the result side refuses words while bytes keep coming.
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef logic [7:0] byte_q_t[$];

  // One result word, laid out in the order of the result interface fields.
  typedef struct packed {
    logic             kind;
    logic [7:0]       sample;
    logic [CNT_W-1:0] idx;
    logic [1:0]       status;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       tc;
    logic [9:0]       period;
    logic             last;
  } pcm_word_t;

  typedef enum logic [1:0] {
    SCAN_WRAP,
    SCAN_BLOCK_HDR,
    SCAN_PCM,
    SCAN_HALT
  } scan_phase_e;

  // Tracks the parse of the current entry and holds the words still due.
  class voc_entry_tracker;
    pcm_word_t         due_words[$];
    int unsigned       mismatches;
    logic [CNT_W-1:0]  cap_reg;
    scan_phase_e       phase;
    int unsigned       hdr_pos;
    int unsigned       blk_pos;
    logic [23:0]       bytes_left;
    logic [7:0]        last_tc;
    logic [7:0]        pend_tc;
    logic [7:0]        type_lo;
    logic [SEEN_W-1:0] seen;
    logic [1:0]        verdict;

    function new();
      cap_reg    = CAP_MAX;
      mismatches = 0;
      clear_entry();
    endfunction

    function void clear_entry();
      phase      = SCAN_WRAP;
      hdr_pos    = 0;
      blk_pos    = 0;
      bytes_left = '0;
      last_tc    = '0;
      pend_tc    = '0;
      type_lo    = '0;
      seen       = '0;
      verdict    = ST_PLAY;
    endfunction

    function void set_cap(logic [CNT_W-1:0] v);
      cap_reg = v;
    endfunction

    function int unsigned cap_now();
      if (cap_reg < CAP_MIN) return CAP_MIN;
      if (cap_reg > CAP_MAX) return CAP_MAX;
      return cap_reg;
    endfunction

    // Advance the parse by one accepted byte and queue the words it causes.
    function void take_byte(logic [7:0] b, logic fin);
      pcm_word_t   w;
      bit          in_wrap;
      int unsigned n_before;
      int unsigned lim;
      int unsigned freq;
      in_wrap  = (phase == SCAN_WRAP);
      n_before = due_words.size();
      case (phase)
        SCAN_WRAP: begin
          if (hdr_pos == POS_MAGIC0 && b != MAGIC0) verdict = ST_REJECT;
          if (hdr_pos == POS_MAGIC1 && b != MAGIC1) verdict = ST_REJECT;
          if (hdr_pos == POS_TYPE_LO) type_lo = b;
          if (hdr_pos == POS_TYPE_HI) begin
            if (verdict == ST_PLAY && {b, type_lo} != WRAP_TYPE_SFX) verdict = ST_NOT_SFX;
            if (verdict != ST_PLAY) phase = SCAN_HALT;
          end
          hdr_pos++;
          if (phase == SCAN_WRAP && hdr_pos >= HDR_TOTAL) phase = SCAN_BLOCK_HDR;
        end
        SCAN_BLOCK_HDR: begin
          if (blk_pos == 0) begin
            if (b != BLK_SOUND) phase = SCAN_HALT;
            else begin
              bytes_left = '0;
              blk_pos    = 1;
            end
          end else if (blk_pos <= 3) begin
            bytes_left[8*(blk_pos-1) +: 8] = b;
            blk_pos++;
          end else if (blk_pos == 4) begin
            pend_tc = b;
            blk_pos = 5;
          end else begin
            blk_pos = 0;
            if (bytes_left < 2 || b != CODEC_PCM8) phase = SCAN_HALT;
            else begin
              last_tc    = pend_tc;
              bytes_left = bytes_left - 24'd2;
              phase      = (bytes_left != 0) ? SCAN_PCM : SCAN_BLOCK_HDR;
            end
          end
        end
        SCAN_PCM: begin
          if (seen < cap_now()) begin
            w        = '0;
            w.kind   = KIND_SAMPLE;
            w.sample = b ^ SIGN_FLIP;
            w.idx    = seen[CNT_W-1:0];
            due_words.push_back(w);
          end
          if (seen < SEEN_MAX) seen++;
          bytes_left = bytes_left - 24'd1;
          if (bytes_left == 0) phase = SCAN_BLOCK_HDR;
        end
        default: ;
      endcase

      if (fin) begin
        w      = '0;
        w.kind = KIND_SUMMARY;
        if (verdict != ST_PLAY) w.status = verdict;
        else if (in_wrap || seen < 2) w.status = ST_REJECT;
        else begin
          w.status = ST_PLAY;
          lim      = (seen < cap_now()) ? seen : cap_now();
          w.cnt    = CNT_W'(lim & ~32'd1);
          w.tc     = last_tc;
          freq     = 32'(FREQ_NUM) / (32'(TC_BASE) - 32'(last_tc));
          w.period = 10'(32'(PERIOD_NUM) / freq);
        end
        due_words.push_back(w);
        clear_entry();
      end

      if (due_words.size() > n_before) due_words[$].last = 1'b1;
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t ERROR %s: expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted word against the oldest word still due.
    function void match_word(pcm_word_t got);
      pcm_word_t want;
      if (due_words.size() == 0) begin
        $display("%0t ERROR unexpected word: expected none actual kind %0d idx %0d status %0d",
                 $time, got.kind, got.idx, got.status);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("sample", $signed(want.sample), $signed(got.sample));
      check_field("sample_index", want.idx, got.idx);
      check_field("status", want.status, got.status);
      check_field("sample_count", want.cnt, got.cnt);
      check_field("time_constant", want.tc, got.tc);
      check_field("period", want.period, got.period);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  vocpbd_entry_if  entry_ch ();
  vocpbd_result_if result_ch ();

  voc_pcm_block_deframer_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .entry       (entry_ch),
    .result      (result_ch)
  );

  voc_entry_tracker tracker = new();

  // Idle densities in percent, changed per entry; zero gives a clean stretch.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  // Raised by the stimulus to ask the result side for one long hold-off.
  bit          hold_off_req = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs or drops a word.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: take words, stall in short random bursts, and serve one
  // long hold-off on request so the block backs up into its input.
  initial begin : result_sink
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check every word the block hands over; values are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
      tracker.match_word({result_ch.kind, result_ch.sample, result_ch.sample_index,
                          result_ch.status, result_ch.sample_count,
                          result_ch.time_constant, result_ch.period, result_ch.last});
  end

  // Offer one byte, maybe after a random gap, and hold it until taken.
  // Leave valid high on return: the next call or drain decides in the same step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      entry_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    entry_ch.valid     <= 1'b1;
    entry_ch.data_byte <= b;
    entry_ch.last_byte <= fin;
    @(posedge clk);
    while (entry_ch.ready !== 1'b1) @(posedge clk);
    tracker.take_byte(b, fin);
  endtask

  task automatic send_entry(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Stop offering, wait for every due word, then let the summary path settle.
  task automatic drain();
    entry_ch.valid <= 1'b0;
    while (tracker.due_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write the sample cap only with the block idle.
  task automatic write_cap(input logic [CNT_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_cap(v);
  endtask

  function automatic byte_q_t entry_head(logic [7:0] m0, logic [7:0] m1, logic [15:0] typ,
                                         int unsigned nfill);
    byte_q_t q;
    q.push_back(m0);
    q.push_back(m1);
    q.push_back(typ[7:0]);
    q.push_back(typ[15:8]);
    repeat (nfill) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic void add_block_hdr(ref byte_q_t q, input logic [7:0] btype,
                                        input logic [23:0] len, input logic [7:0] tc,
                                        input logic [7:0] codec);
    q.push_back(btype);
    q.push_back(len[7:0]);
    q.push_back(len[15:8]);
    q.push_back(len[23:16]);
    q.push_back(tc);
    q.push_back(codec);
  endfunction

  function automatic logic [CNT_W-1:0] pick_cap();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CNT_W'(1);
      2:       return CAP_MIN;
      3:       return CAP_MAX;
      4:       return '1;
      5:       return CNT_W'($urandom_range(3, 8));
      6:       return CNT_W'($urandom_range(9, 40));
      default: return CNT_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // Build one random entry: mostly well-formed with random content, the
  // rest noise, a broken wrapper, or cut short anywhere.
  function automatic byte_q_t make_entry();
    byte_q_t     q;
    int unsigned pick;
    int unsigned nblk;
    int unsigned ndata;
    int unsigned cut;
    logic [23:0] len;
    logic [7:0]  tc;
    logic [7:0]  codec;
    logic [7:0]  btype;
    bit          halted;
    pick   = $urandom_range(0, 99);
    halted = 1'b0;
    if (pick < 8) begin
      repeat ($urandom_range(1, 60)) q.push_back(8'($urandom));
      return q;
    end
    if (pick < 18) begin
      // spoil one of magic or type
      q    = entry_head(MAGIC0, MAGIC1, WRAP_TYPE_SFX, $urandom_range(0, 8));
      pick = $urandom_range(0, 3);
      q[pick] = q[pick] ^ 8'($urandom_range(1, 255));
      return q;
    end
    q    = entry_head(MAGIC0, MAGIC1, WRAP_TYPE_SFX, HDR_FILL);
    nblk = $urandom_range(0, 3);
    for (int i = 0; i < nblk && !halted; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // foreign block type: parsing halts, trailing bytes are junk
        btype = 8'($urandom);
        if (btype == BLK_SOUND) btype = '0;
        add_block_hdr(q, btype, 24'($urandom), 8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
        halted = 1'b1;
      end else begin
        if (pick < 12) len = 24'($urandom_range(2, 24'hFFFFFF));
        else if (pick < 18) len = 24'($urandom_range(0, 1));
        else len = 24'($urandom_range(2, 16));
        case ($urandom_range(0, 9))
          0:       tc = 8'h00;
          1:       tc = 8'hFF;
          default: tc = 8'($urandom);
        endcase
        codec = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : CODEC_PCM8;
        add_block_hdr(q, BLK_SOUND, len, tc, codec);
        ndata = (len >= 2) ? len - 2 : 0;
        // a huge block is always cut short by the end of the entry
        if (ndata > 30) begin
          ndata  = $urandom_range(1, 30);
          halted = 1'b1;
        end
        repeat (ndata) q.push_back(8'($urandom));
        if (len < 2 || codec != CODEC_PCM8) halted = 1'b1;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, q.size());
      q   = q[0:cut-1];
    end
    return q;
  endfunction

  initial begin : stimulus
    byte_q_t     q;
    int unsigned rand_bytes;
    int unsigned n_entries;
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    entry_ch.valid     <= 1'b0;
    entry_ch.data_byte <= '0;
    entry_ch.last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, light idling on both sides.
    gap_pct   = 10;
    stall_pct = 10;
    write_cap('1);  // above the top of the range; clamps to the largest cap

    // entry that ends on its very first byte
    q.delete();
    q.push_back(MAGIC0);
    send_entry(q);
    // bad first magic byte
    send_entry(entry_head(8'h00, MAGIC1, WRAP_TYPE_SFX, 1));
    // good magic, wrong type in the high byte
    send_entry(entry_head(MAGIC0, MAGIC1, 16'h0102, 0));
    // bad second magic together with a wrong type: bad magic wins
    send_entry(entry_head(MAGIC0, 8'h00, 16'h0005, 0));

    // playable entry: extremes of data and time constant, an empty block,
    // then a foreign block that stops the parse
    q = entry_head(MAGIC0, MAGIC1, WRAP_TYPE_SFX, HDR_FILL);
    add_block_hdr(q, BLK_SOUND, 24'd4, 8'h00, CODEC_PCM8);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    add_block_hdr(q, BLK_SOUND, 24'd2, 8'h11, CODEC_PCM8);
    add_block_hdr(q, BLK_SOUND, 24'd3, 8'hFF, CODEC_PCM8);
    q.push_back(8'h7F);
    add_block_hdr(q, 8'h08, 24'd9, 8'h22, CODEC_PCM8);
    send_entry(q);

    // odd cap: a third sample comes out, the count keeps only two
    write_cap(CNT_W'(3));
    q = entry_head(MAGIC0, MAGIC1, WRAP_TYPE_SFX, HDR_FILL);
    add_block_hdr(q, BLK_SOUND, 24'd7, 8'h00, CODEC_PCM8);
    repeat (5) q.push_back(8'($urandom));
    send_entry(q);

    // cap of zero clamps to two; one data byte only, then a too-short block
    write_cap('0);
    q = entry_head(MAGIC0, MAGIC1, WRAP_TYPE_SFX, HDR_FILL);
    add_block_hdr(q, BLK_SOUND, 24'd3, 8'h40, CODEC_PCM8);
    q.push_back(8'h80);
    add_block_hdr(q, BLK_SOUND, 24'd1, 8'h41, CODEC_PCM8);
    q.push_back(8'h55);
    send_entry(q);

    // Random part.
    rand_bytes = 0;
    n_entries  = 0;
    while (rand_bytes < 150 || n_entries < 3) begin
      if ($urandom_range(0, 4) == 0) write_cap(pick_cap());
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      if (n_entries == 1) begin
        // hold the result side off while a block streams in
        q = entry_head(MAGIC0, MAGIC1, WRAP_TYPE_SFX, HDR_FILL);
        add_block_hdr(q, BLK_SOUND, 24'd42, 8'($urandom), CODEC_PCM8);
        repeat (40) q.push_back(8'($urandom));
        hold_off_req = 1'b1;
      end else begin
        q = make_entry();
      end
      send_entry(q);
      rand_bytes += q.size();
      n_entries++;
    end

    // Last part, no idling: one short playable entry at the largest cap.
    write_cap(CAP_MAX);
    gap_pct   = 0;
    stall_pct = 0;
    q = entry_head(MAGIC0, MAGIC1, WRAP_TYPE_SFX, HDR_FILL);
    add_block_hdr(q, BLK_SOUND, 24'd10, 8'h9C, CODEC_PCM8);
    repeat (8) q.push_back(8'($urandom));
    send_entry(q);

    drain();
    if (tracker.mismatches == 0 && tracker.due_words.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/vocpbd_pkg.sv
sv/vocpbd_if.sv
sv/vocpbd_div.sv
sv/vocpbd_parse.sv
sv/voc_pcm_block_deframer_core.sv
dv/voc_pcm_block_deframer_core_tb.sv
